// ----- design/assert_macros.svh -----
// assertion macros shared by the frame parser modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising clock edge outside reset
`define RFP_ASSERT(label, prop) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error("assertion failed: %m");

// same-cycle implication
`define RFP_ASSERT_IMPLY(label, ante, cons) \
   `RFP_ASSERT(label, (ante) |-> (cons))

`endif

// ----- design/rfp_pkg.sv -----
// types and constants of the radio frame parser
`timescale 1ns / 1ps

package rfp_pkg;

   localparam int ADDRESS_BYTES_DEFAULT   = 3;
   localparam int TRAILER_BYTES_DEFAULT   = 6;
   localparam int MAX_FRAME_BYTES_DEFAULT = 32;

   localparam int BYTE_W    = 8;
   localparam int POS_W     = 6;
   localparam int LEN_W     = 6;
   localparam int INDEX_W   = 5;
   localparam int PAYLOAD_W = 5;

   localparam logic [POS_W-1:0]   POS_TOP   = '1;
   localparam logic [INDEX_W-1:0] INDEX_TOP = '1;

   typedef enum logic [2:0] {
      KIND_CTRL0       = 3'd0,
      KIND_CTRL1       = 3'd1,
      KIND_DESTINATION = 3'd2,
      KIND_SOURCE      = 3'd3,
      KIND_COMMAND     = 3'd4,
      KIND_PAYLOAD     = 3'd5,
      KIND_TRAILER     = 3'd6
   } field_kind_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_TOO_SHORT  = 2'd1,
      STATUS_BAD_LENGTH = 2'd2,
      STATUS_MISMATCH   = 2'd3
   } status_type;

   typedef struct packed {
      logic [BYTE_W-1:0] byte_value;
      logic              last_byte;
   } req_item_type;

   typedef struct packed {
      logic [BYTE_W-1:0]    out_byte;
      field_kind_type       field_kind;
      logic [INDEX_W-1:0]   field_index;
      logic                 frame_end;
      status_type           status;
      logic                 has_trailer;
      logic [LEN_W-1:0]     declared_length;
      logic [PAYLOAD_W-1:0] payload_length;
   } rsp_item_type;

endpackage

// ----- design/rfp_input_stage.sv -----
// input register holding one received byte transfer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfp_input_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rfp_pkg::req_item_type in_item,
   output logic                  in_stall,
   output logic                  out_valid,
   output rfp_pkg::req_item_type out_item,
   input  logic                  out_take
);
   import rfp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   logic         load;
   req_item_type item_ff;

   assign in_stall  = valid_ff && !out_take;
   assign load      = in_valid && !in_stall;
   assign valid_in  = load || (valid_ff && !out_take);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   // held byte stays put until the parser takes it
   `RFP_ASSERT(a_held_item_kept, valid_ff && !out_take |=> valid_ff && $stable(item_ff))

endmodule

// ----- design/rfp_field_parser.sv -----
// frame position tracking, field labelling and end-of-frame status
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfp_field_parser #(
   parameter int ADDRESS_BYTES   = rfp_pkg::ADDRESS_BYTES_DEFAULT,
   parameter int TRAILER_BYTES   = rfp_pkg::TRAILER_BYTES_DEFAULT,
   parameter int MAX_FRAME_BYTES = rfp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write,
   input  logic [rfp_pkg::BYTE_W-1:0]    csr_data,
   input  logic                          item_valid,
   input  logic                          item_take,
   input  rfp_pkg::req_item_type         item,
   output rfp_pkg::rsp_item_type         result
);
   import rfp_pkg::*;

   localparam int LEN_X_W       = LEN_W + 1;
   localparam int HEADER_BYTES  = 3 + 2 * ADDRESS_BYTES;
   localparam int SOURCE_POS_I  = 2 + ADDRESS_BYTES;
   localparam int COMMAND_POS_I = 2 + 2 * ADDRESS_BYTES;

   localparam logic [POS_W-1:0]   CTRL1_POS    = POS_W'(1);
   localparam logic [POS_W-1:0]   DEST_POS     = POS_W'(2);
   localparam logic [POS_W-1:0]   SOURCE_POS   = POS_W'(SOURCE_POS_I);
   localparam logic [POS_W-1:0]   COMMAND_POS  = POS_W'(COMMAND_POS_I);
   localparam logic [POS_W-1:0]   PAYLOAD_POS  = POS_W'(COMMAND_POS_I + 1);
   localparam logic [LEN_W-1:0]   HEADER_LEN   = LEN_W'(HEADER_BYTES);
   localparam logic [LEN_W-1:0]   MAX_LEN      = LEN_W'(MAX_FRAME_BYTES);
   localparam logic [LEN_X_W-1:0] HEADER_LEN_X = LEN_X_W'(HEADER_BYTES);
   localparam logic [LEN_X_W-1:0] TRAILER_X    = LEN_X_W'(TRAILER_BYTES);

   logic [BYTE_W-1:0]  trailer_command_ff;
   logic [POS_W-1:0]   pos_ff;
   logic [POS_W-1:0]   pos_in;
   logic [LEN_W-1:0]   length_seen_ff;
   logic [LEN_W-1:0]   length_seen_in;
   logic [BYTE_W-1:0]  command_seen_ff;
   logic [BYTE_W-1:0]  command_seen_in;

   logic               advance;
   logic [LEN_W-1:0]   len;
   logic [BYTE_W-1:0]  cmd;
   logic               len_ok;
   field_kind_type     kind;
   logic [POS_W-1:0]   idx_raw;
   logic [LEN_X_W-1:0] buf_len;
   logic [LEN_X_W-1:0] len_x;
   status_type         status;
   logic               trailer;

   assign advance = item_valid && item_take;

   always_comb begin
      len     = (pos_ff == '0) ? (LEN_W'(item.byte_value[4:0]) + LEN_W'(1)) : length_seen_ff;
      cmd     = (pos_ff == COMMAND_POS) ? item.byte_value : command_seen_ff;
      len_ok  = (len >= HEADER_LEN) && (len <= MAX_LEN);
      len_x   = {1'b0, len};
      buf_len = {1'b0, pos_ff} + LEN_X_W'(1);

      if (pos_ff == '0) begin
         kind    = KIND_CTRL0;
         idx_raw = '0;
      end else if (pos_ff == CTRL1_POS) begin
         kind    = KIND_CTRL1;
         idx_raw = '0;
      end else if (pos_ff < SOURCE_POS) begin
         kind    = KIND_DESTINATION;
         idx_raw = pos_ff - DEST_POS;
      end else if (pos_ff < COMMAND_POS) begin
         kind    = KIND_SOURCE;
         idx_raw = pos_ff - SOURCE_POS;
      end else if (pos_ff == COMMAND_POS) begin
         kind    = KIND_COMMAND;
         idx_raw = '0;
      end else if (pos_ff < len) begin
         kind    = KIND_PAYLOAD;
         idx_raw = pos_ff - PAYLOAD_POS;
      end else begin
         kind    = KIND_TRAILER;
         idx_raw = pos_ff - len;
      end

      status  = STATUS_OK;
      trailer = 1'b0;
      if (item.last_byte) begin
         if (pos_ff == POS_TOP) begin
            status = STATUS_MISMATCH;
         end else if (buf_len < HEADER_LEN_X) begin
            status = STATUS_TOO_SHORT;
         end else if (!len_ok) begin
            status = STATUS_BAD_LENGTH;
         end else if (buf_len == len_x) begin
            status = STATUS_OK;
         end else if ((buf_len == len_x + TRAILER_X) && (cmd == trailer_command_ff)) begin
            status  = STATUS_OK;
            trailer = 1'b1;
         end else begin
            status = STATUS_MISMATCH;
         end
      end

      result.out_byte        = item.byte_value;
      result.field_kind      = kind;
      result.field_index     = (idx_raw > POS_W'(INDEX_TOP)) ? INDEX_TOP
                                                              : idx_raw[INDEX_W-1:0];
      result.frame_end       = item.last_byte;
      result.status          = status;
      result.has_trailer     = trailer;
      result.declared_length = len;
      result.payload_length  = len_ok ? PAYLOAD_W'(len - HEADER_LEN) : '0;
   end

   always_comb begin
      pos_in          = pos_ff;
      length_seen_in  = length_seen_ff;
      command_seen_in = command_seen_ff;
      if (advance) begin
         if (item.last_byte) begin
            pos_in          = '0;
            length_seen_in  = '0;
            command_seen_in = '0;
         end else begin
            pos_in          = (pos_ff == POS_TOP) ? POS_TOP : pos_ff + POS_W'(1);
            length_seen_in  = len;
            command_seen_in = cmd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff             <= '0;
         length_seen_ff     <= '0;
         command_seen_ff    <= '0;
         trailer_command_ff <= '0;
      end else begin
         pos_ff          <= pos_in;
         length_seen_ff  <= length_seen_in;
         command_seen_ff <= command_seen_in;
         if (csr_write) begin
            trailer_command_ff <= csr_data;
         end
      end
   end

   // a frame end restarts the frame state
   `RFP_ASSERT(a_end_clears_pos, advance && item.last_byte |=> pos_ff == '0 && length_seen_ff == '0)
   // a mid-frame byte moves the position by one unless saturated
   `RFP_ASSERT(a_pos_steps, advance && !item.last_byte && pos_ff != POS_TOP |=> pos_ff == $past(pos_ff) + POS_W'(1))

endmodule

// ----- design/rfp_result_stage.sv -----
// result register toward the downstream consumer
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rfp_result_stage (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  rfp_pkg::rsp_item_type in_item,
   output logic                  in_take,
   output logic                  out_valid,
   output rfp_pkg::rsp_item_type out_item,
   input  logic                  out_stall
);
   import rfp_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   logic         load;
   rsp_item_type item_ff;

   assign in_take   = !valid_ff || !out_stall;
   assign load      = in_valid && in_take;
   assign valid_in  = load || (valid_ff && out_stall);
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff <= in_item;
      end
   end

   // trailer is reported only on a good frame end
   `RFP_ASSERT_IMPLY(a_trailer_on_ok_end, valid_ff && item_ff.has_trailer, item_ff.frame_end && item_ff.status == STATUS_OK)
   // error status never shows mid-frame
   `RFP_ASSERT_IMPLY(a_status_at_end, valid_ff && item_ff.status != STATUS_OK, item_ff.frame_end)

endmodule

// ----- design/radio_frame_parser_core.sv -----
// radio frame parser top level
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_stall  | byte_value, last_byte
//   rsp     | out       | rsp_valid / rsp_stall  | out_byte .. payload_length
//   csr     | in        | csr_valid / csr_ready  | trailer_command
//
// one byte per cycle while rsp_stall is low; results pass the input and result registers
// input register, then combinational labelling into the result register
// reset is synchronous, active high, and clears position, length, command and trailer_command
// a stalled result still lets one more byte transfer into the input register
// csr_ready is always high
`timescale 1ns / 1ps

module radio_frame_parser_core #(
   parameter int ADDRESS_BYTES   = rfp_pkg::ADDRESS_BYTES_DEFAULT,
   parameter int TRAILER_BYTES   = rfp_pkg::TRAILER_BYTES_DEFAULT,
   parameter int MAX_FRAME_BYTES = rfp_pkg::MAX_FRAME_BYTES_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,

   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [rfp_pkg::BYTE_W-1:0]       req_byte_value,
   input  logic                             req_last_byte,

   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [rfp_pkg::BYTE_W-1:0]       rsp_out_byte,
   output logic [2:0]                       rsp_field_kind,
   output logic [rfp_pkg::INDEX_W-1:0]      rsp_field_index,
   output logic                             rsp_frame_end,
   output logic [1:0]                       rsp_status,
   output logic                             rsp_has_trailer,
   output logic [rfp_pkg::LEN_W-1:0]        rsp_declared_length,
   output logic [rfp_pkg::PAYLOAD_W-1:0]    rsp_payload_length,

   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [rfp_pkg::BYTE_W-1:0]       csr_trailer_command
);
   import rfp_pkg::*;

   req_item_type req_item;
   req_item_type held_item;
   logic         held_valid;
   logic         parse_take;
   rsp_item_type parse_result;
   rsp_item_type rsp_item;

   assign req_item.byte_value = req_byte_value;
   assign req_item.last_byte  = req_last_byte;
   assign csr_ready           = 1'b1;

   rfp_input_stage u_input_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_item   (req_item),
      .in_stall  (req_stall),
      .out_valid (held_valid),
      .out_item  (held_item),
      .out_take  (parse_take)
   );

   rfp_field_parser #(
      .ADDRESS_BYTES   (ADDRESS_BYTES),
      .TRAILER_BYTES   (TRAILER_BYTES),
      .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
   ) u_field_parser (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_data   (csr_trailer_command),
      .item_valid (held_valid),
      .item_take  (parse_take),
      .item       (held_item),
      .result     (parse_result)
   );

   rfp_result_stage u_result_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (held_valid),
      .in_item   (parse_result),
      .in_take   (parse_take),
      .out_valid (rsp_valid),
      .out_item  (rsp_item),
      .out_stall (rsp_stall)
   );

   assign rsp_out_byte        = rsp_item.out_byte;
   assign rsp_field_kind      = rsp_item.field_kind;
   assign rsp_field_index     = rsp_item.field_index;
   assign rsp_frame_end       = rsp_item.frame_end;
   assign rsp_status          = rsp_item.status;
   assign rsp_has_trailer     = rsp_item.has_trailer;
   assign rsp_declared_length = rsp_item.declared_length;
   assign rsp_payload_length  = rsp_item.payload_length;

endmodule

// ----- tb/rfp_label_checker.sv -----
// checker that predicts and compares the field labels of the radio frame parser
`timescale 1ns / 1ps

module rfp_label_checker
   import rfp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic [BYTE_W-1:0]    req_byte_value,
   input  logic                 req_last_byte,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [BYTE_W-1:0]    rsp_out_byte,
   input  logic [2:0]           rsp_field_kind,
   input  logic [INDEX_W-1:0]   rsp_field_index,
   input  logic                 rsp_frame_end,
   input  logic [1:0]           rsp_status,
   input  logic                 rsp_has_trailer,
   input  logic [LEN_W-1:0]     rsp_declared_length,
   input  logic [PAYLOAD_W-1:0] rsp_payload_length,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [BYTE_W-1:0]    csr_trailer_command,
   output int                   mismatch_count,
   output int                   labels_in_flight
);

   localparam int ADDR   = ADDRESS_BYTES_DEFAULT;
   localparam int TRL    = TRAILER_BYTES_DEFAULT;
   localparam int MAXF   = MAX_FRAME_BYTES_DEFAULT;
   localparam int HDR    = 3 + 2 * ADDR;
   localparam int CMD_AT = 2 + 2 * ADDR;
   localparam int REPORT_LIMIT = 10;

   logic [POS_W-1:0]  position      = '0;
   logic [LEN_W-1:0]  length_held   = '0;
   logic [BYTE_W-1:0] command_held  = '0;
   logic [BYTE_W-1:0] trailer_match = '0;
   rsp_item_type      expected_labels[$];
   int                errors = 0;

   task automatic label_byte(input logic [BYTE_W-1:0] b, input logic last);
      rsp_item_type      r;
      logic [LEN_W-1:0]  len;
      logic [BYTE_W-1:0] cmd;
      logic              len_ok;
      int                idx;
      int                buf_len;
      len = (position == '0) ? LEN_W'(b[4:0]) + 1'b1 : length_held;
      cmd = (int'(position) == CMD_AT) ? b : command_held;
      len_ok = (int'(len) >= HDR) && (int'(len) <= MAXF);
      r = '0;
      r.out_byte = b;
      if (position == '0) begin
         r.field_kind = KIND_CTRL0;
         idx = 0;
      end else if (int'(position) == 1) begin
         r.field_kind = KIND_CTRL1;
         idx = 0;
      end else if (int'(position) < 2 + ADDR) begin
         r.field_kind = KIND_DESTINATION;
         idx = int'(position) - 2;
      end else if (int'(position) < CMD_AT) begin
         r.field_kind = KIND_SOURCE;
         idx = int'(position) - (2 + ADDR);
      end else if (int'(position) == CMD_AT) begin
         r.field_kind = KIND_COMMAND;
         idx = 0;
      end else if (position < len) begin
         r.field_kind = KIND_PAYLOAD;
         idx = int'(position) - (CMD_AT + 1);
      end else begin
         r.field_kind = KIND_TRAILER;
         idx = int'(position) - int'(len);
      end
      r.field_index = (idx > int'(INDEX_TOP)) ? INDEX_TOP : idx[INDEX_W-1:0];
      r.declared_length = len;
      r.payload_length = len_ok ? PAYLOAD_W'(int'(len) - HDR) : '0;
      if (last) begin
         r.frame_end = 1'b1;
         buf_len = int'(position) + 1;
         if (position == POS_TOP) begin
            r.status = STATUS_MISMATCH;
         end else if (buf_len < HDR) begin
            r.status = STATUS_TOO_SHORT;
         end else if (!len_ok) begin
            r.status = STATUS_BAD_LENGTH;
         end else if (buf_len == int'(len)) begin
            r.status = STATUS_OK;
         end else if (buf_len == int'(len) + TRL && cmd == trailer_match) begin
            r.status = STATUS_OK;
            r.has_trailer = 1'b1;
         end else begin
            r.status = STATUS_MISMATCH;
         end
         position = '0;
         length_held = '0;
         command_held = '0;
      end else begin
         position = (position == POS_TOP) ? POS_TOP : position + 1'b1;
         length_held = len;
         command_held = cmd;
      end
      expected_labels.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_item_type observed;
      rsp_item_type wanted;
      if (reset) begin
         position = '0;
         length_held = '0;
         command_held = '0;
         trailer_match = '0;
         expected_labels.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            trailer_match = csr_trailer_command;
         end
         if (req_valid && !req_stall) begin
            label_byte(req_byte_value, req_last_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            observed.out_byte = rsp_out_byte;
            observed.field_kind = field_kind_type'(rsp_field_kind);
            observed.field_index = rsp_field_index;
            observed.frame_end = rsp_frame_end;
            observed.status = status_type'(rsp_status);
            observed.has_trailer = rsp_has_trailer;
            observed.declared_length = rsp_declared_length;
            observed.payload_length = rsp_payload_length;
            if (expected_labels.size() == 0) begin
               errors++;
               if (errors <= REPORT_LIMIT) begin
                  $display("%0t: unexpected result transfer, byte %02h kind %0d", $time,
                     observed.out_byte, observed.field_kind);
               end
            end else begin
               wanted = expected_labels.pop_front();
               if (observed.out_byte !== wanted.out_byte ||
                   observed.field_kind !== wanted.field_kind ||
                   observed.field_index !== wanted.field_index ||
                   observed.frame_end !== wanted.frame_end ||
                   observed.status !== wanted.status ||
                   observed.has_trailer !== wanted.has_trailer ||
                   observed.declared_length !== wanted.declared_length ||
                   observed.payload_length !== wanted.payload_length) begin
                  errors++;
                  if (errors <= REPORT_LIMIT) begin
                     $display({"%0t: label mismatch\n",
                        "   expected byte %02h kind %0d index %0d end %0b status %0d",
                        " trailer %0b declared %0d payload %0d\n",
                        "   actual   byte %02h kind %0d index %0d end %0b status %0d",
                        " trailer %0b declared %0d payload %0d"}, $time,
                        wanted.out_byte, wanted.field_kind, wanted.field_index,
                        wanted.frame_end, wanted.status, wanted.has_trailer,
                        wanted.declared_length, wanted.payload_length,
                        observed.out_byte, observed.field_kind, observed.field_index,
                        observed.frame_end, observed.status, observed.has_trailer,
                        observed.declared_length, observed.payload_length);
                  end
               end
            end
         end
      end
      mismatch_count <= errors;
      labels_in_flight <= expected_labels.size();
   end

endmodule

// ----- tb/tb_radio_frame_parser_core.sv -----
// testbench top for the radio frame parser: stimulus, handshake idling and verdict
`timescale 1ns / 1ps

module tb_radio_frame_parser_core;
   import rfp_pkg::*;

   localparam int ADDR         = ADDRESS_BYTES_DEFAULT;
   localparam int TRL          = TRAILER_BYTES_DEFAULT;
   localparam int MAXF         = MAX_FRAME_BYTES_DEFAULT;
   localparam int HDR          = 3 + 2 * ADDR;
   localparam int CMD_AT       = 2 + 2 * ADDR;
   localparam int PHASES       = 5;
   localparam int PHASE_BYTES  = 120;
   localparam int HOLD_CYCLES  = 80;
   localparam int SETTLE       = 4;
   localparam int DRAIN_CYCLES = 10;
   localparam int CYCLE_LIMIT  = 400000;

   typedef enum {
      FRAME_EXACT,
      FRAME_TRAILER,
      FRAME_WRONG_CMD,
      FRAME_SHORT,
      FRAME_BAD_LENGTH,
      FRAME_ANY_LENGTH,
      FRAME_SATURATE
   } frame_shape_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [BYTE_W-1:0]    req_byte_value = '0;
   logic                 req_last_byte = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [BYTE_W-1:0]    rsp_out_byte;
   logic [2:0]           rsp_field_kind;
   logic [INDEX_W-1:0]   rsp_field_index;
   logic                 rsp_frame_end;
   logic [1:0]           rsp_status;
   logic                 rsp_has_trailer;
   logic [LEN_W-1:0]     rsp_declared_length;
   logic [PAYLOAD_W-1:0] rsp_payload_length;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [BYTE_W-1:0]    csr_trailer_command = '0;

   int                   mismatch_count;
   int                   labels_in_flight;
   int                   cycle_count = 0;
   int                   bytes_sent = 0;
   logic                 idling_on = 1'b1;
   logic                 long_hold = 1'b0;
   logic                 hold_done = 1'b0;
   logic [BYTE_W-1:0]    trailer_cmd_now = '0;

   radio_frame_parser_core dut (.*);

   rfp_label_checker checker_i (.*);

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // result side back-pressure
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (long_hold && !hold_done) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_done <= 1'b1;
         end else if (idling_on && $urandom_range(0, 3) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 40)) @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
      req_valid <= 1'b1;
      req_byte_value <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
      if (idling_on && !(long_hold && !hold_done) && $urandom_range(0, 7) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   endtask

   task automatic send_frame(input int n_bytes, input logic [4:0] length_code,
                             input logic [BYTE_W-1:0] cmd);
      logic [BYTE_W-1:0] b;
      for (int i = 0; i < n_bytes; i++) begin
         b = BYTE_W'($urandom);
         if (i == 0) begin
            b[4:0] = length_code;
         end
         if (i == CMD_AT) begin
            b = cmd;
         end
         send_byte(b, i == n_bytes - 1);
      end
   endtask

   function automatic frame_shape_type pick_shape();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 38) return FRAME_EXACT;
      if (roll < 60) return FRAME_TRAILER;
      if (roll < 65) return FRAME_WRONG_CMD;
      if (roll < 73) return FRAME_SHORT;
      if (roll < 81) return FRAME_BAD_LENGTH;
      if (roll < 97) return FRAME_ANY_LENGTH;
      return FRAME_SATURATE;
   endfunction

   task automatic send_shaped_frame(input frame_shape_type shape);
      int len;
      len = $urandom_range(HDR, MAXF);
      case (shape)
         FRAME_EXACT: begin
            send_frame(len, 5'(len - 1), BYTE_W'($urandom));
         end
         FRAME_TRAILER: begin
            send_frame(len + TRL, 5'(len - 1), trailer_cmd_now);
         end
         FRAME_WRONG_CMD: begin
            send_frame(len + TRL, 5'(len - 1),
               trailer_cmd_now ^ BYTE_W'($urandom_range(1, 255)));
         end
         FRAME_SHORT: begin
            send_frame($urandom_range(1, HDR - 1), 5'($urandom), BYTE_W'($urandom));
         end
         FRAME_BAD_LENGTH: begin
            send_frame($urandom_range(HDR, 40), 5'($urandom_range(0, HDR - 2)),
               BYTE_W'($urandom));
         end
         FRAME_ANY_LENGTH: begin
            send_frame($urandom_range(1, 45), 5'($urandom),
               ($urandom_range(0, 1) == 0) ? trailer_cmd_now : BYTE_W'($urandom));
         end
         default: begin
            send_frame($urandom_range(63, 72), 5'($urandom), BYTE_W'($urandom));
         end
      endcase
   endtask

   task automatic wait_all_results();
      @(posedge clock);
      while (labels_in_flight != 0) @(posedge clock);
   endtask

   task automatic write_trailer_command(input logic [BYTE_W-1:0] value);
      csr_valid <= 1'b1;
      csr_trailer_command <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      trailer_cmd_now = value;
   endtask

   initial begin
      logic [BYTE_W-1:0] b;
      int                phase_start;
      frame_shape_type   opener;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // lone byte that is both control 0 and the final byte
      send_byte(8'hFF, 1'b1);
      // shortest declared length plus trailer, command matching the reset register value
      for (int i = 0; i < HDR + TRL; i++) begin
         if (i == 0) begin
            b = 8'h08;
         end else if (i == CMD_AT) begin
            b = 8'h00;
         end else begin
            b = (i % 2 == 1) ? 8'hFF : 8'h00;
         end
         send_byte(b, i == HDR + TRL - 1);
      end
      send_frame(HDR - 1, 5'd31, 8'hFF);

      for (int phase = 0; phase < PHASES; phase++) begin
         if (phase > 0) begin
            req_valid <= 1'b0;
            wait_all_results();
            repeat (SETTLE) @(posedge clock);
            case (phase)
               1: write_trailer_command(8'hFF);
               2: write_trailer_command(8'h00);
               default: write_trailer_command(BYTE_W'($urandom));
            endcase
         end
         if (phase == PHASES - 1) begin
            idling_on <= 1'b0;
         end
         if (phase == 2) begin
            long_hold <= 1'b1;
         end
         phase_start = bytes_sent;
         if (phase > 0) begin
            case (phase)
               1: opener = FRAME_SATURATE;
               2: opener = FRAME_BAD_LENGTH;
               3: opener = FRAME_WRONG_CMD;
               default: opener = FRAME_TRAILER;
            endcase
            send_shaped_frame(opener);
         end
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            send_shaped_frame(pick_shape());
         end
      end

      req_valid <= 1'b0;
      wait_all_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
